@@ design/spe_pkg.sv @@
`default_nettype none
package spe_pkg;

	localparam int unsigned PKT_LEN = 9;
	localparam int unsigned CNT_W = $clog2(PKT_LEN);

	localparam logic [CNT_W-1:0] BYTE_HDR0 = CNT_W'(0);
	localparam logic [CNT_W-1:0] BYTE_HDR1 = CNT_W'(1);
	localparam logic [CNT_W-1:0] BYTE_ID   = CNT_W'(2);
	localparam logic [CNT_W-1:0] BYTE_LEN  = CNT_W'(3);
	localparam logic [CNT_W-1:0] BYTE_INST = CNT_W'(4);
	localparam logic [CNT_W-1:0] BYTE_ADDR = CNT_W'(5);
	localparam logic [CNT_W-1:0] BYTE_POSL = CNT_W'(6);
	localparam logic [CNT_W-1:0] BYTE_POSH = CNT_W'(7);
	localparam logic [CNT_W-1:0] BYTE_CHK  = CNT_W'(PKT_LEN - 1);

	localparam logic [7:0] HDR_BYTE  = 8'hFF;
	localparam logic [7:0] LEN_BYTE  = 8'h05;
	localparam logic [7:0] INST_BYTE = 8'h03;
	localparam logic [7:0] ADDR_BYTE = 8'h1E;

	localparam logic signed [16:0] POS_OFFSET = 17'sd19200;
	localparam logic [15:0] POS_SCALE = 16'd55924;
	localparam logic [32:0] POS_ROUND = 33'd1048576;
	localparam int unsigned POS_SHIFT = 21;

	localparam logic [7:0] REG_MIN_ANGLE = 8'd0;
	localparam logic [7:0] REG_MAX_ANGLE = 8'd1;

	localparam logic signed [15:0] MIN_ANGLE_RST = -16'sd1920;
	localparam logic signed [15:0] MAX_ANGLE_RST = 16'sd1920;

	typedef struct packed {
		logic [7:0]  servo_id;
		logic [15:0] pos;
		logic [7:0]  chk;
	} pkt_t;

	typedef struct packed {
		logic valid;
		pkt_t data;
	} push_t;

endpackage
`default_nettype wire

@@ design/spe_front.sv @@
`default_nettype none
module spe_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [7:0]          servo_id,
	input  wire logic signed [15:0]  angle,
	input  wire logic signed [15:0]  min_angle,
	input  wire logic signed [15:0]  max_angle,
	output spe_pkg::push_t           push,
	input  wire logic                push_ready
);

	logic              v_s1, v_s2;
	logic [7:0]        id_s1, id_s2;
	logic [15:0]       off_s1;
	logic [31:0]       prod_s2;
	logic              adv;
	logic              load_s1;
	logic signed [15:0] d;
	logic signed [16:0] off;
	logic [32:0]       rounded;
	logic [15:0]       pos;
	logic [7:0]        sum;

	assign adv = !v_s2 || push_ready;
	assign load_s1 = adv || !v_s1;
	assign in_ready = load_s1;

	always_comb begin
		if (angle < min_angle) begin
			d = min_angle;
		end else if (angle > max_angle) begin
			d = max_angle;
		end else begin
			d = angle;
		end
		off = 17'(d) + spe_pkg::POS_OFFSET;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			id_s1  <= servo_id;
			off_s1 <= off[16] ? 16'd0 : off[15:0];
		end
		if (adv && v_s1) begin
			id_s2   <= id_s1;
			prod_s2 <= 32'(off_s1) * 32'(spe_pkg::POS_SCALE);
		end
	end

	always_comb begin
		rounded = 33'(prod_s2) + spe_pkg::POS_ROUND;
		pos = 16'(rounded >> spe_pkg::POS_SHIFT);
		sum = id_s2 + spe_pkg::LEN_BYTE + spe_pkg::INST_BYTE + spe_pkg::ADDR_BYTE
			+ pos[7:0] + pos[15:8];
		push.valid = v_s2;
		push.data.servo_id = id_s2;
		push.data.pos = pos;
		push.data.chk = ~sum;
	end

endmodule
`default_nettype wire

@@ design/spe_queue.sv @@
`default_nettype none
module spe_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire spe_pkg::push_t push,
	output logic             push_ready,
	output logic             pop_valid,
	output spe_pkg::pkt_t    pop_data,
	input  wire logic        pop
);

	spe_pkg::pkt_t mem_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push, do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push.valid && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

endmodule
`default_nettype wire

@@ design/spe_back.sv @@
`default_nettype none
module spe_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pop_valid,
	input  wire spe_pkg::pkt_t pop_data,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             out_last
);

	logic                      busy_q;
	logic [spe_pkg::CNT_W-1:0] cnt_q;
	spe_pkg::pkt_t             pkt_q;
	logic                      done;

	assign out_valid = busy_q;
	assign done = busy_q && out_ready && (cnt_q == spe_pkg::BYTE_CHK);
	assign pop = pop_valid && (!busy_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				cnt_q  <= spe_pkg::BYTE_HDR0;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (busy_q && out_ready) begin
				cnt_q <= cnt_q + spe_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pkt_q <= pop_data;
		end
	end

	always_comb begin
		out_last = (cnt_q == spe_pkg::BYTE_CHK);
		case (cnt_q)
			spe_pkg::BYTE_HDR0: out_byte = spe_pkg::HDR_BYTE;
			spe_pkg::BYTE_HDR1: out_byte = spe_pkg::HDR_BYTE;
			spe_pkg::BYTE_ID:   out_byte = pkt_q.servo_id;
			spe_pkg::BYTE_LEN:  out_byte = spe_pkg::LEN_BYTE;
			spe_pkg::BYTE_INST: out_byte = spe_pkg::INST_BYTE;
			spe_pkg::BYTE_ADDR: out_byte = spe_pkg::ADDR_BYTE;
			spe_pkg::BYTE_POSL: out_byte = pkt_q.pos[7:0];
			spe_pkg::BYTE_POSH: out_byte = pkt_q.pos[15:8];
			spe_pkg::BYTE_CHK:  out_byte = pkt_q.chk;
			default:            out_byte = spe_pkg::HDR_BYTE;
		endcase
	end

endmodule
`default_nettype wire

@@ design/servo_position_packet_encoder_unit.sv @@
`default_nettype none
// Channel   Direction  Beat contents
// s_axis    in         one command: servo id and requested angle
// m_axis    out        one packet byte, tlast on the checksum byte
// cfg       in         one register write: index and 16-bit value
//
// Every command becomes nine output beats, one per cycle while m_axis_tready
// is high; the serializer takes the next command as the checksum byte leaves.
// A command passes the s1 and s2 registers, a queue entry and the serializer's
// packet register to its first beat. A two-entry queue between the position
// pipeline and serializer lets the input accept during a stall until it fills.
// Reset returns the limits to -1920 and 1920 and empties the pipeline.
module servo_position_packet_encoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // servo_id [7:0], angle [23:8]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // packet_byte [7:0]
	output logic             m_axis_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic signed [15:0] min_angle_q, max_angle_q;
	spe_pkg::push_t     push;
	logic               push_ready;
	logic               pop_valid, pop;
	spe_pkg::pkt_t      pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_angle_q <= spe_pkg::MIN_ANGLE_RST;
			max_angle_q <= spe_pkg::MAX_ANGLE_RST;
		end else if (cfg_valid) begin
			if (cfg_index == spe_pkg::REG_MIN_ANGLE) begin
				min_angle_q <= cfg_data;
			end else if (cfg_index == spe_pkg::REG_MAX_ANGLE) begin
				max_angle_q <= cfg_data;
			end
		end
	end

	spe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.servo_id   (s_axis_tdata[7:0]),
		.angle      (s_axis_tdata[23:8]),
		.min_angle  (min_angle_q),
		.max_angle  (max_angle_q),
		.push       (push),
		.push_ready (push_ready)
	);

	spe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop        (pop)
	);

	spe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none
module tb;

	localparam int ANGLE_OFFSET = 19200;
	localparam logic [39:0] ANGLE_SCALE = 40'd55924;
	localparam logic [39:0] HALF_LSB = 40'd1048576;
	localparam int SCALE_SHIFT = 21;
	localparam int PACKET_BYTES = 9;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} packet_byte_t;

	class packet_predictor;
		packet_byte_t expected_bytes[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function void note_command(logic [7:0] id, logic signed [15:0] angle,
				logic signed [15:0] lo, logic signed [15:0] hi);
			logic signed [15:0] clamped;
			int offset;
			logic [39:0] product;
			logic [15:0] pos;
			logic [7:0] bytes [PACKET_BYTES];
			logic [7:0] sum;
			packet_byte_t b;
			clamped = angle;
			if (angle < lo) begin
				clamped = lo;
			end else if (angle > hi) begin
				clamped = hi;
			end
			offset = clamped + ANGLE_OFFSET;
			if (offset < 0) begin
				offset = 0;
			end
			product = 40'(offset) * ANGLE_SCALE + HALF_LSB;
			pos = 16'(product >> SCALE_SHIFT);
			bytes[0] = spe_pkg::HDR_BYTE;
			bytes[1] = spe_pkg::HDR_BYTE;
			bytes[2] = id;
			bytes[3] = spe_pkg::LEN_BYTE;
			bytes[4] = spe_pkg::INST_BYTE;
			bytes[5] = spe_pkg::ADDR_BYTE;
			bytes[6] = pos[7:0];
			bytes[7] = pos[15:8];
			sum = 8'd0;
			for (int k = 2; k < PACKET_BYTES - 1; k++) begin
				sum = sum + bytes[k];
			end
			bytes[8] = ~sum;
			for (int k = 0; k < PACKET_BYTES; k++) begin
				b.data = bytes[k];
				b.last = (k == PACKET_BYTES - 1);
				expected_bytes.push_back(b);
			end
		endfunction

		function void check_byte(logic [7:0] data, logic last);
			packet_byte_t b;
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected output beat data %h last %b", $time, data, last);
				errors++;
				return;
			end
			b = expected_bytes.pop_front();
			if (data !== b.data) begin
				$display("%0t: packet byte expected %h actual %h", $time, b.data, data);
				errors++;
			end
			if (last !== b.last) begin
				$display("%0t: tlast expected %b actual %b", $time, b.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = 24'd0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = 8'd0;
	logic [15:0] cfg_data = 16'd0;

	packet_predictor predictor = new();
	logic signed [15:0] min_limit = spe_pkg::MIN_ANGLE_RST;
	logic signed [15:0] max_limit = spe_pkg::MAX_ANGLE_RST;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit hold_start = 1'b0;
	int hold_left = 0;

	servo_position_packet_encoder_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_start) begin
			hold_start = 1'b0;
			hold_left = 300;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			predictor.check_byte(m_axis_tdata, m_axis_tlast);
		end
	end

	task automatic send_command(input logic [7:0] id, input logic signed [15:0] angle);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {angle, id};
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		predictor.note_command(id, angle, min_limit, max_limit);
	endtask

	task automatic write_register(input logic [7:0] index, input logic signed [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		if (index == spe_pkg::REG_MIN_ANGLE) begin
			min_limit = value;
		end else begin
			max_limit = value;
		end
		@(posedge clk);
	endtask

	task automatic drain_packets();
		s_axis_tvalid <= 1'b0;
		while (predictor.pending() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
	endtask

	task automatic set_limits(input int lo, input int hi);
		drain_packets();
		write_register(spe_pkg::REG_MIN_ANGLE, 16'(lo));
		write_register(spe_pkg::REG_MAX_ANGLE, 16'(hi));
	endtask

	function automatic logic signed [15:0] pick_angle();
		int choice;
		choice = $urandom_range(3);
		if (choice == 2) begin
			return 16'(int'(min_limit) + int'($urandom_range(4)) - 2);
		end else if (choice == 3) begin
			return 16'(int'(max_limit) + int'($urandom_range(4)) - 2);
		end
		return 16'($urandom);
	endfunction

	initial begin
		int lo;
		int hi;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 11;
		rx_idle_pct = 79;
		send_command(8'h00, -16'sd32768);
		send_command(8'hFF, 16'sd32767);
		send_command(8'hAA, 16'sd0);
		send_command(8'h55, -16'sd1920);
		send_command(8'h01, 16'sd1920);
		send_command(8'hFE, -16'sd1921);
		send_command(8'h7F, 16'sd1921);
		send_command(8'h80, -16'sd1919);
		send_command(8'h3C, 16'sd1919);
		set_limits(-19200, 19200);
		send_command(8'h00, -16'sd19200);
		send_command(8'hFF, 16'sd19200);
		send_command(8'h12, -16'sd19201);
		send_command(8'hED, 16'sd19201);
		send_command(8'h5A, -16'sd32768);
		send_command(8'hA5, 16'sd32767);
		send_command(8'h33, -16'sd1);
		send_command(8'hCC, 16'sd1);
		set_limits(19200, -19200);
		send_command(8'h10, 16'sd0);
		send_command(8'h20, 16'sd19200);
		send_command(8'h30, 16'sd32767);
		send_command(8'h40, -16'sd32768);
		set_limits(0, 0);
		send_command(8'h50, 16'sd5);
		send_command(8'h60, -16'sd5);

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin lo = -19200; hi = 19200; end
				1: begin lo = 19200; hi = -19200; end
				2: begin lo = 0; hi = 0; end
				3: begin
					lo = int'($urandom_range(38400)) - 19200;
					hi = lo + int'($urandom_range(19200 - lo));
				end
				4: begin
					lo = int'($urandom_range(38400)) - 19200;
					hi = int'($urandom_range(38400)) - 19200;
				end
				default: begin lo = -1920; hi = 1920; end
			endcase
			set_limits(lo, hi);
			tx_idle_pct = (phase < 2) ? 11 : (phase < 4) ? 79 : 0;
			rx_idle_pct = (phase < 2) ? 79 : (phase < 4) ? 11 : 0;
			for (int n = 0; n < 65; n++) begin
				if (phase == 4 && n == 5) begin
					hold_start = 1'b1;
				end
				send_command(8'($urandom), pick_angle());
			end
		end

		drain_packets();
		if (predictor.errors == 0 && predictor.pending() == 0) begin
			$display("servo_position_packet_encoder_unit verification clean");
		end else begin
			$display("servo_position_packet_encoder_unit verification failed");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("servo_position_packet_encoder_unit verification failed");
		$finish;
	end
endmodule
`default_nettype wire
